/* src/dad_pkg.sv */
package dad_pkg;

	localparam logic [13:0] MAX_YEAR   = 14'd9999;
	localparam logic [13:0] ERA_YEARS  = 14'd400;
	localparam logic [8:0]  ERA_LAST   = 9'd399;
	localparam logic [8:0]  YEAR_DAYS  = 9'd365;
	localparam logic [8:0]  LEAP_DAYS  = 9'd366;
	localparam logic [3:0]  LAST_MONTH = 4'd12;

	localparam logic [1:0] ERR_NONE  = 2'd0;
	localparam logic [1:0] ERR_DATE  = 2'd1;
	localparam logic [1:0] ERR_RANGE = 2'd2;

	typedef struct packed {
		logic [13:0] start_year;
		logic [3:0]  start_month;
		logic [4:0]  start_day;
		logic [15:0] add_days;
	} dad_query_t;

	typedef struct packed {
		logic [13:0] end_year;
		logic [3:0]  end_month;
		logic [4:0]  end_day;
		logic [1:0]  error_code;
	} dad_answer_t;

	// Length of month m (1 to 12); February follows the leap flag.
	function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
		logic [4:0] d;
		case (m)
			4'd2:                   d = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
			default:                d = 5'd31;
		endcase
		return d;
	endfunction

	// Leap test from the year taken modulo 400.
	function automatic logic era_leap(input logic [8:0] r);
		logic [8:0] c;
		if (r >= 9'd300) begin
			c = r - 9'd300;
		end else if (r >= 9'd200) begin
			c = r - 9'd200;
		end else if (r >= 9'd100) begin
			c = r - 9'd100;
		end else begin
			c = r;
		end
		return ((r[1:0] == 2'b00) && (c != 9'd0)) || (r == 9'd0);
	endfunction

endpackage

/* src/date_add_days.sv */
// Channel  Payload       Handshake
// query    dad_query_t   query_valid / query_stall
// answer   dad_answer_t  answer_valid / answer_stall
//
// One shared adder on the day count walks months and years one step a cycle.
// After a query is accepted the sequencer steps ERA (year modulo 400), CHECK,
// DOY, YEAR and MONTH, and FINISH registers the answer; the next query is taken
// once the sequencer is back in idle.
// arst_n clears the sequencer and the answer register; a new query is taken
// while the previous answer still waits, and a finished answer waits for room.
module date_add_days import dad_pkg::*; #(
	parameter int DAYS_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        query_valid,
	output logic        query_stall,
	input  dad_query_t  query,
	output logic        answer_valid,
	input  logic        answer_stall,
	output dad_answer_t answer
);

	localparam int NW = (DAYS_WIDTH < 16) ? DAYS_WIDTH : 16;
	localparam int KW = ((DAYS_WIDTH > 9) ? DAYS_WIDTH : 9) + 1;

	typedef enum logic [2:0] {
		ST_IDLE, ST_ERA, ST_CHECK, ST_DOY, ST_YEAR, ST_MONTH, ST_FINISH
	} state_t;

	state_t      state_q;
	logic [13:0] year_q;
	logic [13:0] rem_q;
	logic [3:0]  month_q;
	logic [4:0]  day_q;
	logic [3:0]  idx_q;
	logic [NW-1:0] n_q;
	logic [KW-1:0] k_q;
	logic [1:0]  err_q;
	logic        answer_valid_q;
	dad_answer_t answer_q;

	logic          leap;
	logic [4:0]    dim_idx;
	logic [4:0]    dim_mon;
	logic [8:0]    diy;
	logic [KW-1:0] operand;
	logic          subtract;
	logic [KW-1:0] k_next;
	logic [13:0]   year_inc;
	logic          room;

	assign leap     = era_leap(rem_q[8:0]);
	assign dim_idx  = month_days(idx_q, leap);
	assign dim_mon  = month_days(month_q, leap);
	assign diy      = leap ? LEAP_DAYS : YEAR_DAYS;
	assign year_inc = year_q + 14'd1;
	assign room     = !answer_valid_q || !answer_stall;

	// The shared day-count unit: adds in the day-of-year walk, subtracts later.
	always_comb begin
		operand  = KW'(dim_mon);
		subtract = 1'b1;
		case (state_q)
			ST_DOY: begin
				subtract = 1'b0;
				operand  = (idx_q < month_q) ? KW'(dim_idx) : KW'(n_q);
			end
			ST_YEAR: operand = KW'(diy);
			default: operand = KW'(dim_mon);
		endcase
		k_next = subtract ? (k_q - operand) : (k_q + operand);
	end

	assign query_stall  = (state_q != ST_IDLE);
	assign answer_valid = answer_valid_q;
	assign answer       = answer_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			answer_valid_q <= 1'b0;
			answer_q       <= '0;
			year_q         <= '0;
			rem_q          <= '0;
			month_q        <= '0;
			day_q          <= '0;
			idx_q          <= '0;
			n_q            <= '0;
			k_q            <= '0;
			err_q          <= ERR_NONE;
		end else begin
			if ((state_q == ST_FINISH) && room) begin
				answer_valid_q <= 1'b1;
			end else if (answer_valid_q && !answer_stall) begin
				answer_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (query_valid) begin
						year_q  <= query.start_year;
						rem_q   <= query.start_year;
						month_q <= query.start_month;
						day_q   <= query.start_day;
						n_q     <= query.add_days[NW-1:0];
						err_q   <= ERR_NONE;
						if ((query.start_year == 14'd0) || (query.start_year > MAX_YEAR) ||
							(query.start_month == 4'd0) || (query.start_month > LAST_MONTH) ||
							(query.start_day == 5'd0)) begin
							err_q   <= ERR_DATE;
							state_q <= ST_FINISH;
						end else begin
							state_q <= ST_ERA;
						end
					end
				end
				ST_ERA: begin
					if (rem_q >= ERA_YEARS) begin
						rem_q <= rem_q - ERA_YEARS;
					end else begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (day_q > dim_mon) begin
						err_q   <= ERR_DATE;
						state_q <= ST_FINISH;
					end else begin
						k_q     <= KW'(day_q);
						idx_q   <= 4'd1;
						state_q <= ST_DOY;
					end
				end
				ST_DOY: begin
					k_q <= k_next;
					if (idx_q < month_q) begin
						idx_q <= idx_q + 4'd1;
					end else begin
						state_q <= ST_YEAR;
					end
				end
				ST_YEAR: begin
					if (k_q > KW'(diy)) begin
						if (year_inc > MAX_YEAR) begin
							err_q   <= ERR_RANGE;
							state_q <= ST_FINISH;
						end else begin
							k_q    <= k_next;
							year_q <= year_inc;
							rem_q  <= (rem_q[8:0] == ERA_LAST) ? 14'd0 : rem_q + 14'd1;
						end
					end else begin
						month_q <= 4'd1;
						state_q <= ST_MONTH;
					end
				end
				ST_MONTH: begin
					if ((month_q < LAST_MONTH) && (k_q > KW'(dim_mon))) begin
						k_q     <= k_next;
						month_q <= month_q + 4'd1;
					end else begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (room) begin
						if (err_q == ERR_NONE) begin
							answer_q.end_year  <= year_q;
							answer_q.end_month <= month_q;
							answer_q.end_day   <= k_q[4:0];
						end else begin
							answer_q.end_year  <= '0;
							answer_q.end_month <= '0;
							answer_q.end_day   <= '0;
						end
						answer_q.error_code <= err_q;
						state_q             <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* tb/sv/date_add_days_checker.sv */
`timescale 1ns / 1ps

module date_add_days_checker import dad_pkg::*; #(
	parameter int DAYS_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        query_valid,
	input  logic        query_stall,
	input  dad_query_t  query,
	input  logic        answer_valid,
	input  logic        answer_stall,
	input  dad_answer_t answer,
	output int          failures,
	output int          outstanding
);

	dad_answer_t expected_answers[$];
	dad_answer_t oldest;
	int          mismatches = 0;

	function automatic bit leap_year(input int unsigned y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic int unsigned month_length(input int unsigned y, input int unsigned m);
		int unsigned len;
		case (m)
			2: begin
				len = leap_year(y) ? 29 : 28;
			end
			4, 6, 9, 11: begin
				len = 30;
			end
			default: begin
				len = 31;
			end
		endcase
		return len;
	endfunction

	function automatic int unsigned year_length(input int unsigned y);
		return leap_year(y) ? int'(LEAP_DAYS) : int'(YEAR_DAYS);
	endfunction

	// Start date becomes a day of its year; whole years and then months are
	// peeled off that count until it falls within one month.
	function automatic dad_answer_t predict_end_date(input dad_query_t q);
		dad_answer_t r;
		int unsigned yr;
		int unsigned mo;
		int unsigned m;
		int unsigned remaining;
		r = '0;
		yr = q.start_year;
		mo = q.start_month;
		remaining = q.start_day;
		if (yr < 1 || yr > MAX_YEAR || mo < 1 || mo > LAST_MONTH || remaining < 1 ||
		    remaining > month_length(yr, mo)) begin
			r.error_code = ERR_DATE;
			return r;
		end
		for (m = 1; m < mo; m++) begin
			remaining += month_length(yr, m);
		end
		remaining += int'(q.add_days) & ((1 << DAYS_WIDTH) - 1);
		while (remaining > year_length(yr)) begin
			remaining -= year_length(yr);
			yr++;
			if (yr > MAX_YEAR) begin
				r.error_code = ERR_RANGE;
				return r;
			end
		end
		mo = 1;
		while (mo < LAST_MONTH && remaining > month_length(yr, mo)) begin
			remaining -= month_length(yr, mo);
			mo++;
		end
		r.end_year   = 14'(yr);
		r.end_month  = 4'(mo);
		r.end_day    = 5'(remaining);
		r.error_code = ERR_NONE;
		return r;
	endfunction

	function automatic int field_mismatch(input string name, input int unsigned wanted,
	                                      input int unsigned seen);
		if (wanted == seen) begin
			return 0;
		end
		$display("%0t: answer %s mismatch, expected %0d, actual %0d", $time, name, wanted, seen);
		return 1;
	endfunction

	always @(posedge clk) begin
		// The answer side is handled first; an answer never belongs to a query
		// taken at the same edge.
		if (arst_n && answer_valid && !answer_stall) begin
			if (expected_answers.size() == 0) begin
				$display("%0t: answer transfer with nothing expected, expected none, actual %p",
				         $time, answer);
				mismatches++;
			end else begin
				oldest = expected_answers.pop_front();
				mismatches += field_mismatch("end_year", oldest.end_year, answer.end_year);
				mismatches += field_mismatch("end_month", oldest.end_month, answer.end_month);
				mismatches += field_mismatch("end_day", oldest.end_day, answer.end_day);
				mismatches += field_mismatch("error_code", oldest.error_code, answer.error_code);
			end
		end
		if (arst_n && query_valid && !query_stall) begin
			expected_answers.push_back(predict_end_date(query));
		end
		failures    <= mismatches;
		outstanding <= expected_answers.size();
	end

endmodule

/* tb/sv/date_add_days_test.sv */
`timescale 1ns / 1ps

module date_add_days_test;
	import dad_pkg::*;

	localparam int DAYS_WIDTH     = 16;
	localparam int RANDOM_ITEMS   = 1750;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES  = 250;

	logic        clk;
	logic        arst_n       = 1'b0;
	logic        query_valid  = 1'b0;
	logic        query_stall;
	dad_query_t  query        = '0;
	logic        answer_valid;
	logic        answer_stall = 1'b0;
	dad_answer_t answer;

	int failures;
	int outstanding;
	int tx_idle_pct  = 6;
	int rx_idle_pct  = 73;
	int quiet_cycles = 0;

	date_add_days #(
		.DAYS_WIDTH(DAYS_WIDTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.query_valid(query_valid),
		.query_stall(query_stall),
		.query(query),
		.answer_valid(answer_valid),
		.answer_stall(answer_stall),
		.answer(answer)
	);

	date_add_days_checker #(
		.DAYS_WIDTH(DAYS_WIDTH)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.query_valid(query_valid),
		.query_stall(query_stall),
		.query(query),
		.answer_valid(answer_valid),
		.answer_stall(answer_stall),
		.answer(answer),
		.failures(failures),
		.outstanding(outstanding)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(posedge clk) begin
		answer_stall <= ($urandom_range(99) < rx_idle_pct);
	end

	always @(posedge clk) begin
		if (!arst_n || (query_valid && !query_stall) || (answer_valid && !answer_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("date_add_days_test failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic dad_query_t make_query(input int unsigned y, input int unsigned m,
	                                          input int unsigned d, input int unsigned n);
		dad_query_t q;
		q.start_year  = 14'(y);
		q.start_month = 4'(m);
		q.start_day   = 5'(d);
		q.add_days    = 16'(n);
		return q;
	endfunction

	// Mostly plausible dates with random offsets; a fifth is raw noise over
	// the full field widths.
	function automatic dad_query_t random_query();
		int unsigned pick;
		int unsigned y;
		int unsigned d;
		int unsigned n;
		pick = $urandom_range(99);
		if (pick < 20) begin
			return make_query($urandom_range(16383), $urandom_range(15), $urandom_range(31),
			                  $urandom_range(65535));
		end
		pick = $urandom_range(99);
		if (pick < 55) begin
			y = $urandom_range(1, 9999);
		end else if (pick < 70) begin
			y = $urandom_range(9800, 9999);
		end else if (pick < 85) begin
			y = 100 * $urandom_range(1, 99) + $urandom_range(0, 1);
		end else begin
			y = $urandom_range(1, 500);
		end
		d = ($urandom_range(99) < 75) ? $urandom_range(1, 28) : $urandom_range(28, 31);
		pick = $urandom_range(99);
		if (pick < 50) begin
			n = $urandom_range(65535);
		end else if (pick < 75) begin
			n = $urandom_range(800);
		end else begin
			n = $urandom_range(62);
		end
		return make_query(y, $urandom_range(1, 12), d, n);
	endfunction

	task automatic send_query(input dad_query_t q);
		while ($urandom_range(99) < tx_idle_pct) begin
			query_valid <= 1'b0;
			@(posedge clk);
		end
		query       <= q;
		query_valid <= 1'b1;
		@(posedge clk);
		while (query_stall) begin
			@(posedge clk);
		end
	endtask

	task automatic wait_for_answers();
		query_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) begin
			@(posedge clk);
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_query(make_query(2024, 1, 15, 0));
		send_query(make_query(1, 1, 1, 0));
		send_query(make_query(1, 1, 1, 65535));
		send_query(make_query(9999, 12, 31, 0));
		send_query(make_query(9999, 12, 31, 1));
		send_query(make_query(9999, 1, 1, 364));
		send_query(make_query(9999, 1, 1, 365));
		send_query(make_query(9820, 6, 30, 65535));
		send_query(make_query(2000, 2, 29, 0));
		send_query(make_query(1900, 2, 29, 0));
		send_query(make_query(2023, 2, 29, 5));
		send_query(make_query(2024, 2, 28, 1));
		send_query(make_query(2100, 2, 28, 1));
		send_query(make_query(0, 6, 15, 10));
		send_query(make_query(10000, 1, 1, 0));
		send_query(make_query(16383, 15, 31, 65535));
		send_query(make_query(2020, 0, 10, 3));
		send_query(make_query(2020, 13, 10, 3));
		send_query(make_query(2020, 4, 31, 3));
		send_query(make_query(2020, 5, 0, 3));
		send_query(make_query(2020, 12, 31, 1));
		send_query(make_query(1999, 12, 31, 366));
		send_query(make_query(2400, 1, 1, 65535));
		send_query(make_query(1600, 3, 1, 32768));

		// Hold the sender back until the block has emptied out.
		wait_for_answers();

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					tx_idle_pct = 6;
					rx_idle_pct = 73;
				end
				1: begin
					tx_idle_pct = 73;
					rx_idle_pct = 6;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			repeat (RANDOM_ITEMS / 3) begin
				send_query(random_query());
			end
			wait_for_answers();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (failures == 0 && outstanding == 0) begin
			$display("date_add_days_test passed");
		end else begin
			$display("date_add_days_test failed");
		end
		$finish;
	end

endmodule
